// File: rtl/clook_pkg.sv
`default_nettype none

package clook_pkg;

    localparam int MAX_REQ = 16;
    localparam int CNT_W   = $clog2(MAX_REQ + 1);
    localparam int TRACK_W = 16;
    localparam int SEEK_W  = 22;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ROTATE = 2'd2,
        OP_SHIFT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               valid;
        logic               le;
    } t_link;

endpackage

`default_nettype wire

// File: rtl/clook_cell.sv
`default_nettype none

module clook_cell (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  clook_pkg::t_cell_op          i_op,
    input  wire  [clook_pkg::TRACK_W-1:0]      i_new_track,
    input  wire  [clook_pkg::TRACK_W-1:0]      i_head_track,
    input  wire  clook_pkg::t_link             i_left,
    input  wire  clook_pkg::t_link             i_right,
    output clook_pkg::t_link                   o_link
);

    logic [clook_pkg::TRACK_W-1:0] r_track;
    logic [clook_pkg::TRACK_W-1:0] n_track;
    logic                          r_valid;
    logic                          n_valid;
    logic                          w_gt;

    assign w_gt         = !r_valid || (r_track > i_new_track);
    assign o_link.track = r_track;
    assign o_link.valid = r_valid;
    assign o_link.le    = r_valid && (r_track <= i_new_track);

    always_comb begin
        n_track = r_track;
        n_valid = r_valid;
        unique case (i_op)
            clook_pkg::OP_HOLD: begin
            end
            clook_pkg::OP_INSERT: begin
                if (w_gt) begin
                    if (i_left.le) begin
                        n_track = i_new_track;
                        n_valid = 1'b1;
                    end else begin
                        n_track = i_left.track;
                        n_valid = i_left.valid;
                    end
                end
            end
            clook_pkg::OP_ROTATE: begin
                n_track = i_right.valid ? i_right.track : i_head_track;
            end
            clook_pkg::OP_SHIFT: begin
                n_track = i_right.track;
                n_valid = i_right.valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_track <= n_track;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// File: rtl/clook_disk_request_scheduler.sv
// Channel   Direction  Handshake                      Payload
// request   in         i_in_valid / o_in_ready        i_request_track, i_batch_last
// result    out        o_out_valid / i_out_ready      o_served_track, o_seek_total,
//                                                     o_nothing_served, o_order_end
// config    in         i_cfg_we                       i_cfg_wdata (start head)
//
// Each request beat is inserted into a sorted chain of cells while a cell is free;
// beats that find the chain full are dropped. After the closing beat, the chain moves
// each request below the head to its end and drops each one equal to the head, then
// gives one result beat per cycle through cell zero while the result is not stalled.
// Reset is synchronous and active low; it empties the chain and the output.
// A stalled result holds the output register and the chain; requests are taken
// again once the final result of the batch is in the output register.
`default_nettype none

module clook_disk_request_scheduler (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [clook_pkg::TRACK_W-1:0]     i_request_track,
    input  wire                               i_batch_last,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [clook_pkg::TRACK_W-1:0]     o_served_track,
    output logic [clook_pkg::SEEK_W-1:0]      o_seek_total,
    output logic                              o_nothing_served,
    output logic                              o_order_end,
    input  wire                               i_cfg_we,
    input  wire  [clook_pkg::TRACK_W-1:0]     i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_ROT  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    localparam clook_pkg::t_link TIE_LEFT  = '{track: '0, valid: 1'b0, le: 1'b1};
    localparam clook_pkg::t_link TIE_RIGHT = '{track: '0, valid: 1'b0, le: 1'b0};

    t_state                           r_state;
    t_state                           n_state;
    logic [clook_pkg::TRACK_W-1:0]    r_start_head;
    logic [clook_pkg::TRACK_W-1:0]    r_head_now;
    logic [clook_pkg::TRACK_W-1:0]    n_head_now;
    logic [clook_pkg::SEEK_W-1:0]     r_seek;
    logic [clook_pkg::SEEK_W-1:0]     n_seek;
    logic [clook_pkg::CNT_W-1:0]      r_count;
    logic [clook_pkg::CNT_W-1:0]      n_count;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [clook_pkg::TRACK_W-1:0]    r_out_track;
    logic [clook_pkg::TRACK_W-1:0]    n_out_track;
    logic [clook_pkg::SEEK_W-1:0]     r_out_seek;
    logic [clook_pkg::SEEK_W-1:0]     n_out_seek;
    logic                             r_out_none;
    logic                             n_out_none;
    logic                             r_out_end;
    logic                             n_out_end;

    clook_pkg::t_cell_op              w_op;
    clook_pkg::t_link                 w_link [clook_pkg::MAX_REQ];
    logic [clook_pkg::MAX_REQ-1:0]    w_valid;
    logic                             w_accept;
    logic                             w_room;
    logic                             w_out_free;
    logic [clook_pkg::TRACK_W-1:0]    w_dist;
    logic [clook_pkg::TRACK_W-1:0]    w_track0;
    logic                             w_valid0;
    logic                             w_valid1;

    assign o_in_ready       = (r_state == S_LOAD);
    assign w_accept         = i_in_valid && o_in_ready;
    assign w_room           = (r_count < clook_pkg::CNT_W'(clook_pkg::MAX_REQ));
    assign w_out_free       = !r_out_valid || i_out_ready;
    assign w_track0         = w_link[0].track;
    assign w_valid0         = w_link[0].valid;
    assign w_valid1         = w_link[1].valid;
    assign w_dist           = (w_track0 > r_head_now) ? (w_track0 - r_head_now)
                                                      : (r_head_now - w_track0);
    assign o_out_valid      = r_out_valid;
    assign o_served_track   = r_out_track;
    assign o_seek_total     = r_out_seek;
    assign o_nothing_served = r_out_none;
    assign o_order_end      = r_out_end;

    genvar g;
    generate
        for (g = 0; g < clook_pkg::MAX_REQ; g++) begin : g_cell
            clook_pkg::t_link w_left;
            clook_pkg::t_link w_right;
            if (g == 0) begin : g_first
                assign w_left = TIE_LEFT;
            end else begin : g_mid_l
                assign w_left = w_link[g-1];
            end
            if (g == clook_pkg::MAX_REQ - 1) begin : g_last
                assign w_right = TIE_RIGHT;
            end else begin : g_mid_r
                assign w_right = w_link[g+1];
            end
            assign w_valid[g] = w_link[g].valid;
            clook_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (w_op),
                .i_new_track  (i_request_track),
                .i_head_track (w_track0),
                .i_left       (w_left),
                .i_right      (w_right),
                .o_link       (w_link[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_head_now  = r_head_now;
        n_seek      = r_seek;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_track = r_out_track;
        n_out_seek  = r_out_seek;
        n_out_none  = r_out_none;
        n_out_end   = r_out_end;
        w_op        = clook_pkg::OP_HOLD;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_op    = clook_pkg::OP_INSERT;
                        n_count = r_count + 1'b1;
                    end
                    if (i_batch_last) begin
                        n_state    = S_ROT;
                        n_head_now = r_start_head;
                        n_seek     = '0;
                    end
                end
            end
            S_ROT: begin
                if ((r_count != '0) && w_valid0 && (w_track0 <= r_head_now)) begin
                    w_op    = (w_track0 < r_head_now) ? clook_pkg::OP_ROTATE
                                                      : clook_pkg::OP_SHIFT;
                    n_count = r_count - 1'b1;
                end else begin
                    n_count = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_valid0) begin
                        w_op        = clook_pkg::OP_SHIFT;
                        n_seek      = r_seek + clook_pkg::SEEK_W'(w_dist);
                        n_head_now  = w_track0;
                        n_out_track = w_track0;
                        n_out_seek  = r_seek + clook_pkg::SEEK_W'(w_dist);
                        n_out_none  = 1'b0;
                        n_out_end   = !w_valid1;
                        if (!w_valid1) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_out_track = r_head_now;
                        n_out_seek  = '0;
                        n_out_none  = 1'b1;
                        n_out_end   = 1'b1;
                        n_state     = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_track <= n_out_track;
        r_out_seek  <= n_out_seek;
        r_out_none  <= n_out_none;
        r_out_end   <= n_out_end;
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_start_head <= '0;
            r_head_now   <= '0;
            r_seek       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_now  <= n_head_now;
            r_seek      <= n_seek;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_start_head <= i_cfg_wdata;
            end
        end
    end

    // Occupied cells always form an unbroken run starting at cell zero.
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("chain holds a gap");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nothing_served) |-> (o_order_end && (o_seek_total == '0)))
        else $error("empty result not flagged as final");

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_batch_last) |=> (r_state == S_ROT) && (r_seek == '0))
        else $error("closing beat did not start the drain");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_LOAD) |=> !w_valid0)
        else $error("chain not drained at end of batch");

endmodule

`default_nettype wire
